>>> sv/odmm_pkg.sv
`timescale 1ns / 1ps
// Package for the omni drive motor mixer.
// Holds the sequencer state type, register indexes, constants and the divide-by-255 helper.
// No dependencies.
package odmm_pkg;

  localparam int unsigned NUM_WHEELS  = 4;
  localparam int unsigned DIV_STEPS   = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 7;

  localparam logic [7:0]  AXIS_SCALE     = 8'd180;
  localparam logic [17:0] SQRT_HALF_Q16  = 18'd46341;

  localparam logic signed [8:0]  AXIS_MID   = 9'sd90;
  localparam logic signed [7:0]  AXIS_POS   = 8'sd90;
  localparam logic signed [7:0]  AXIS_NEG   = -8'sd90;
  localparam logic signed [7:0]  AXIS_DEAD  = 8'sd8;
  localparam logic signed [7:0]  TURN_DEAD  = 8'sd2;
  localparam logic signed [11:0] BASE_MID   = 12'sd90;
  localparam logic signed [11:0] TARGET_MIN = 12'sd5;
  localparam logic signed [11:0] TARGET_MAX = 12'sd175;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TURN      = 3'd0,
    CFG_TURN_GAIN     = 3'd1,
    CFG_HANDICAP      = 3'd2,
    CFG_MOTOR_OFFSET  = 3'd3,
    CFG_REVERSE_DRIVE = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_BASE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Exact floor(n / 255) for any 16-bit n below 65535, using n = 255q + r.
  function automatic logic [8:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = 17'(n) + 17'(n[15:8]) + 17'd1;
    return t[16:8];
  endfunction

endpackage

>>> sv/omni_drive_motor_mixer.sv
`timescale 1ns / 1ps
// Omni drive motor mixer: joystick sample in, four slew-limited wheel commands out.
// Depends on odmm_pkg.
//
//   channel | ports                                                | direction
//   --------+------------------------------------------------------+----------
//   in      | in_valid, in_stall, in_stick_*, in_hold_l2, in_pad_* | sink
//   out     | out_valid, out_stall, out_wheel_*                    | source
//   cfg     | cfg_we, cfg_index, cfg_data                          | sink
//
// An item goes from acceptance through axis mapping and base sum, then through the shared
// multiplier and 8-step handicap divider for each wheel in turn, then into the output
// register. The next item is accepted once that result has been loaded.
// Reset clears the internal wheel commands to zero and the config registers to their defaults.
// A result held by out_stall does not block the next item, only the next result.
module omni_drive_motor_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_stick_y,
  input  logic [7:0]                         in_stick_x,
  input  logic [7:0]                         in_stick_turn,
  input  logic                               in_hold_l2,
  input  logic                               in_pad_up,
  input  logic                               in_pad_down,
  input  logic                               in_pad_left,
  input  logic                               in_pad_right,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_wheel_one,
  output logic [7:0]                         out_wheel_two,
  output logic [7:0]                         out_wheel_three,
  output logic [7:0]                         out_wheel_four,
  input  logic                               cfg_we,
  input  logic [odmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [odmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import odmm_pkg::*;

  state_t state_r, state_nxt;

  logic [6:0]        max_turn_r;
  logic [2:0]        turn_gain_r;
  logic [3:0]        handicap_r;
  logic signed [5:0] motor_offset_r;
  logic              reverse_drive_r;

  logic [7:0] stick_y_r, stick_x_r, stick_turn_r;
  logic       hold_l2_r, pad_up_r, pad_down_r, pad_left_r, pad_right_r;

  logic signed [7:0]  y_r, x_r, turn_r;
  logic signed [11:0] base_r;
  logic [1:0]         idx_r;
  logic [2:0]         cnt_r;
  logic               neg_r;
  logic [7:0]         quo_r;
  logic [4:0]         rem_r;
  logic [7:0]         cmd_r [NUM_WHEELS];

  logic       out_valid_r;
  logic [7:0] out_one_r, out_two_r, out_three_r, out_four_r;

  logic accept, load_out, last_step, last_wheel;

  // Axis and turn mapping.
  logic [15:0]       y_prod, x_prod, t_prod;
  logic [8:0]        y_q, x_q, t_q;
  logic signed [7:0] y_map, x_map, turn_map, y_sel, x_sel, y_dz, x_dz, turn_dz;
  logic signed [8:0] turn_wide;

  always_comb begin
    y_prod    = 16'(stick_y_r) * 16'(AXIS_SCALE);
    x_prod    = 16'(stick_x_r) * 16'(AXIS_SCALE);
    t_prod    = 16'(stick_turn_r) * 16'({max_turn_r, 1'b0});
    y_q       = div255(y_prod);
    x_q       = div255(x_prod);
    t_q       = div255(t_prod);
    y_map     = 8'(AXIS_MID - $signed(y_q));
    x_map     = 8'(AXIS_MID - $signed(x_q));
    turn_wide = $signed(t_q) - $signed({2'b00, max_turn_r});
    turn_map  = 8'(turn_wide);
    y_sel     = y_map;
    x_sel     = x_map;
    if (!hold_l2_r) begin
      priority if (pad_up_r) begin
        y_sel = AXIS_POS;
        x_sel = '0;
      end else if (pad_down_r) begin
        y_sel = AXIS_NEG;
        x_sel = '0;
      end else if (pad_left_r) begin
        y_sel = '0;
        x_sel = AXIS_POS;
      end else if (pad_right_r) begin
        y_sel = '0;
        x_sel = AXIS_NEG;
      end else begin
        y_sel = y_map;
        x_sel = x_map;
      end
    end
    y_dz    = (y_sel > -AXIS_DEAD && y_sel < AXIS_DEAD) ? '0 : y_sel;
    x_dz    = (x_sel > -AXIS_DEAD && x_sel < AXIS_DEAD) ? '0 : x_sel;
    turn_dz = (turn_map > -TURN_DEAD && turn_map < TURN_DEAD) ? '0 : turn_map;
  end

  // Base term shared by all wheels.
  logic signed [11:0] gain_prod, base_val;
  always_comb begin
    gain_prod = $signed({9'b0, turn_gain_r}) * 12'(turn_r);
    base_val  = gain_prod + BASE_MID + 12'(motor_offset_r);
  end

  // Translation term of the current wheel and its scaling by 1/sqrt2.
  logic signed [8:0]  tr_raw, tr_val;
  logic signed [26:0] tr_prod;
  logic signed [10:0] p_val;
  logic [10:0]        p_mag;
  always_comb begin
    unique case (idx_r)
      2'd0: tr_raw = 9'(x_r) - 9'(y_r);
      2'd1: tr_raw = -(9'(x_r) + 9'(y_r));
      2'd2: tr_raw = 9'(y_r) - 9'(x_r);
      2'd3: tr_raw = 9'(x_r) + 9'(y_r);
      default: tr_raw = '0;
    endcase
    tr_val  = reverse_drive_r ? -tr_raw : tr_raw;
    tr_prod = 27'(tr_val) * $signed({9'b0, SQRT_HALF_Q16});
    p_val   = tr_prod[26:16];
    p_mag   = p_val[10] ? 11'(-p_val) : 11'(p_val);
  end

  // One restoring divide step by the handicap.
  logic [3:0] div_val;
  logic [4:0] div_shift, div_rem;
  logic       div_bit;
  always_comb begin
    div_val   = (handicap_r == '0) ? 4'd1 : handicap_r;
    div_shift = {rem_r[3:0], quo_r[7]};
    div_bit   = div_shift >= {1'b0, div_val};
    div_rem   = div_bit ? div_shift - {1'b0, div_val} : div_shift;
  end

  // Floor quotient, target clamp and slew step.
  logic [8:0]         q_adj;
  logic signed [9:0]  fq;
  logic signed [11:0] sum_val;
  logic [7:0]         target, cur, cmd_step;
  always_comb begin
    q_adj    = {1'b0, quo_r} + 9'(rem_r != '0);
    fq       = neg_r ? -$signed({1'b0, q_adj}) : $signed({2'b00, quo_r});
    sum_val  = base_r + 12'(fq);
    if (sum_val < TARGET_MIN) begin
      target = 8'(TARGET_MIN);
    end else if (sum_val > TARGET_MAX) begin
      target = 8'(TARGET_MAX);
    end else begin
      target = sum_val[7:0];
    end
    cur = cmd_r[idx_r];
    if (target > cur) begin
      cmd_step = cur + 8'd1;
    end else if (target < cur) begin
      cmd_step = cur - 8'd1;
    end else begin
      cmd_step = cur;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = ST_BASE;
      ST_BASE:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   if (last_step) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = last_wheel ? ST_DONE : ST_MUL;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer control outputs.
  always_comb begin
    in_stall   = state_r != ST_IDLE;
    accept     = state_r == ST_IDLE && in_valid;
    load_out   = state_r == ST_DONE && (!out_valid_r || !out_stall);
    last_step  = cnt_r == 3'(DIV_STEPS - 1);
    last_wheel = idx_r == 2'(NUM_WHEELS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      max_turn_r      <= 7'd30;
      turn_gain_r     <= 3'd1;
      handicap_r      <= 4'd1;
      motor_offset_r  <= '0;
      reverse_drive_r <= 1'b0;
      idx_r           <= '0;
      cnt_r           <= '0;
      for (int i = 0; i < NUM_WHEELS; i++) cmd_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out | (out_valid_r & out_stall);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_TURN:      max_turn_r      <= cfg_data;
          CFG_TURN_GAIN:     turn_gain_r     <= cfg_data[2:0];
          CFG_HANDICAP:      handicap_r      <= cfg_data[3:0];
          CFG_MOTOR_OFFSET:  motor_offset_r  <= cfg_data[5:0];
          CFG_REVERSE_DRIVE: reverse_drive_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == ST_BASE) idx_r <= '0;
      if (state_r == ST_MUL) cnt_r <= '0;
      if (state_r == ST_DIV) cnt_r <= cnt_r + 3'd1;
      if (state_r == ST_APPLY) begin
        cmd_r[idx_r] <= cmd_step;
        idx_r        <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stick_y_r    <= in_stick_y;
      stick_x_r    <= in_stick_x;
      stick_turn_r <= in_stick_turn;
      hold_l2_r    <= in_hold_l2;
      pad_up_r     <= in_pad_up;
      pad_down_r   <= in_pad_down;
      pad_left_r   <= in_pad_left;
      pad_right_r  <= in_pad_right;
    end
    if (state_r == ST_MAP) begin
      y_r    <= y_dz;
      x_r    <= x_dz;
      turn_r <= turn_dz;
    end
    if (state_r == ST_BASE) base_r <= base_val;
    if (state_r == ST_MUL) begin
      neg_r <= p_val[10];
      quo_r <= p_mag[7:0];
      rem_r <= '0;
    end
    if (state_r == ST_DIV) begin
      quo_r <= {quo_r[6:0], div_bit};
      rem_r <= div_rem;
    end
    if (load_out) begin
      out_one_r   <= cmd_r[0];
      out_two_r   <= cmd_r[1];
      out_three_r <= cmd_r[2];
      out_four_r  <= cmd_r[3];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_one   = out_one_r;
  assign out_wheel_two   = out_two_r;
  assign out_wheel_three = out_three_r;
  assign out_wheel_four  = out_four_r;

endmodule

>>> test/omni_drive_motor_mixer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for omni_drive_motor_mixer: a queue-fed driver, a result monitor
// and an in-bench mixer model that predicts the four slew-limited wheel commands.
// Depends on odmm_pkg and the omni_drive_motor_mixer RTL.
module omni_drive_motor_mixer_test;
  import odmm_pkg::*;

  typedef struct packed {
    logic [7:0] stick_y;
    logic [7:0] stick_x;
    logic [7:0] stick_turn;
    logic       hold_l2;
    logic       pad_up;
    logic       pad_down;
    logic       pad_left;
    logic       pad_right;
  } sample_t;

  typedef logic [3:0][7:0] wheels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_stick_y = '0;
  logic [7:0] in_stick_x = '0;
  logic [7:0] in_stick_turn = '0;
  logic in_hold_l2 = 1'b0;
  logic in_pad_up = 1'b0;
  logic in_pad_down = 1'b0;
  logic in_pad_left = 1'b0;
  logic in_pad_right = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_wheel_one;
  logic [7:0] out_wheel_two;
  logic [7:0] out_wheel_three;
  logic [7:0] out_wheel_four;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [6:0] max_turn_r = 7'd30;
  logic [2:0] turn_gain_r = 3'd1;
  logic [3:0] handicap_r = 4'd1;
  logic signed [5:0] motor_offset_r = 6'sd0;
  logic reverse_r = 1'b0;
  wheels_t wheel_cmd = '0;

  sample_t sample_q[$];
  wheels_t wheel_expect_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  string wheel_name[4] = '{"one", "two", "three", "four"};

  omni_drive_motor_mixer u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_stick_y(in_stick_y),
    .in_stick_x(in_stick_x),
    .in_stick_turn(in_stick_turn),
    .in_hold_l2(in_hold_l2),
    .in_pad_up(in_pad_up),
    .in_pad_down(in_pad_down),
    .in_pad_left(in_pad_left),
    .in_pad_right(in_pad_right),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_wheel_one(out_wheel_one),
    .out_wheel_two(out_wheel_two),
    .out_wheel_three(out_wheel_three),
    .out_wheel_four(out_wheel_four),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic wheels_t mix_wheels(sample_t s, wheels_t cur);
    int y, x, m, turn, div, base, t, tgt, pos;
    int tr[4];
    longint den, num, q;
    wheels_t nxt;
    y = 90 - (int'(s.stick_y) * 180) / 255;
    x = 90 - (int'(s.stick_x) * 180) / 255;
    m = int'(max_turn_r);
    turn = (int'(s.stick_turn) * 2 * m) / 255 - m;
    div = (handicap_r == 0) ? 1 : int'(handicap_r);
    if (!s.hold_l2) begin
      if (s.pad_up) begin
        y = 90;
        x = 0;
      end else if (s.pad_down) begin
        y = -90;
        x = 0;
      end else if (s.pad_left) begin
        y = 0;
        x = 90;
      end else if (s.pad_right) begin
        y = 0;
        x = -90;
      end
    end
    if (y > -8 && y < 8) y = 0;
    if (x > -8 && x < 8) x = 0;
    if (turn > -2 && turn < 2) turn = 0;
    tr[0] = x - y;
    tr[1] = -(x + y);
    tr[2] = y - x;
    tr[3] = x + y;
    base = int'(turn_gain_r) * turn + 90 + int'(motor_offset_r);
    den = longint'(65536) * div;
    for (int i = 0; i < 4; i++) begin
      t = reverse_r ? -tr[i] : tr[i];
      num = longint'(t) * 46341 + longint'(base) * den;
      q = num / den;
      if (q < 5) q = 5;
      else if (q > 175) q = 175;
      tgt = int'(q);
      pos = int'(cur[i]);
      if (tgt > pos) pos++;
      else if (tgt < pos) pos--;
      nxt[i] = 8'(pos);
    end
    return nxt;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    sample_t taken;
    sample_t next_s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        taken = {in_stick_y, in_stick_x, in_stick_turn, in_hold_l2,
                 in_pad_up, in_pad_down, in_pad_left, in_pad_right};
        wheel_cmd = mix_wheels(taken, wheel_cmd);
        wheel_expect_q.push_back(wheel_cmd);
      end
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_s = sample_q.pop_front();
        in_stick_y <= next_s.stick_y;
        in_stick_x <= next_s.stick_x;
        in_stick_turn <= next_s.stick_turn;
        in_hold_l2 <= next_s.hold_l2;
        in_pad_up <= next_s.pad_up;
        in_pad_down <= next_s.pad_down;
        in_pad_left <= next_s.pad_left;
        in_pad_right <= next_s.pad_right;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    wheels_t got;
    wheels_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_wheel_four, out_wheel_three, out_wheel_two, out_wheel_one};
      if (wheel_expect_q.size() == 0) begin
        $display("%0t unexpected result: got %0d %0d %0d %0d", $time,
                 got[0], got[1], got[2], got[3]);
        fail_count++;
      end else begin
        want = wheel_expect_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t wheel_%s: expected %0d, actual %0d", $time, wheel_name[i],
                     want[i], got[i]);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_TURN: max_turn_r = value[6:0];
      CFG_TURN_GAIN: turn_gain_r = value[2:0];
      CFG_HANDICAP: handicap_r = value[3:0];
      CFG_MOTOR_OFFSET: motor_offset_r = value[5:0];
      CFG_REVERSE_DRIVE: reverse_r = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int mt, input int tg, input int hc, input int mo,
                               input int rv);
    write_reg(CFG_MAX_TURN, 7'(mt));
    write_reg(CFG_TURN_GAIN, 7'(tg));
    write_reg(CFG_HANDICAP, 7'(hc));
    write_reg(CFG_MOTOR_OFFSET, 7'(mo));
    write_reg(CFG_REVERSE_DRIVE, 7'(rv));
  endtask

  task automatic set_pacing(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 65;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 65;
      end
      default: begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
    endcase
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || wheel_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic sample_t make_sample(int y, int x, int t, logic l2, logic [3:0] pads);
    sample_t s;
    s.stick_y = 8'(y);
    s.stick_x = 8'(x);
    s.stick_turn = 8'(t);
    s.hold_l2 = l2;
    {s.pad_up, s.pad_down, s.pad_left, s.pad_right} = pads;
    return s;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 8'd0;
          1: return 8'd255;
          2: return 8'd1;
          default: return 8'd254;
        endcase
      end
      1: return 8'($urandom_range(137, 118));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    s.stick_y = pick_byte();
    s.stick_x = pick_byte();
    s.stick_turn = pick_byte();
    s.hold_l2 = 1'($urandom_range(1));
    if ($urandom_range(99) < 35)
      {s.pad_up, s.pad_down, s.pad_left, s.pad_right} = 4'($urandom_range(15, 1));
    else
      {s.pad_up, s.pad_down, s.pad_left, s.pad_right} = 4'b0000;
    return s;
  endfunction

  // Holding one stick position for a run of items lets the wheel commands slew all the
  // way to their targets and into the clamps; short runs and noise cover the rest.
  task automatic queue_runs(input int count);
    sample_t hold_s;
    sample_t s;
    int run_len;
    int queued;
    queued = 0;
    while (queued < count) begin
      hold_s = pick_sample();
      run_len = ($urandom_range(99) < 20) ? 1 : $urandom_range(120, 2);
      for (int k = 0; k < run_len && queued < count; k++) begin
        s = hold_s;
        if ($urandom_range(99) < 10) s.stick_turn = 8'($urandom_range(255));
        if ($urandom_range(99) < 5) s.hold_l2 = ~s.hold_l2;
        sample_q.push_back(s);
        queued++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    set_pacing(0);
    sample_q.push_back(make_sample(0, 0, 0, 1'b1, 4'b0000));
    sample_q.push_back(make_sample(255, 255, 255, 1'b1, 4'b0000));
    sample_q.push_back(make_sample(0, 255, 128, 1'b0, 4'b0000));
    sample_q.push_back(make_sample(255, 0, 127, 1'b0, 4'b0000));
    sample_q.push_back(make_sample(127, 128, 128, 1'b0, 4'b0000));
    sample_q.push_back(make_sample(117, 139, 124, 1'b0, 4'b0000));
    sample_q.push_back(make_sample(118, 138, 133, 1'b0, 4'b0000));
    sample_q.push_back(make_sample(40, 200, 0, 1'b0, 4'b1000));
    sample_q.push_back(make_sample(40, 200, 255, 1'b0, 4'b0100));
    sample_q.push_back(make_sample(40, 200, 64, 1'b0, 4'b0010));
    sample_q.push_back(make_sample(40, 200, 192, 1'b0, 4'b0001));
    sample_q.push_back(make_sample(40, 200, 128, 1'b1, 4'b1000));
    sample_q.push_back(make_sample(40, 200, 128, 1'b1, 4'b0100));
    sample_q.push_back(make_sample(40, 200, 128, 1'b1, 4'b0010));
    sample_q.push_back(make_sample(40, 200, 128, 1'b1, 4'b0001));
    sample_q.push_back(make_sample(0, 0, 0, 1'b0, 4'b1100));
    sample_q.push_back(make_sample(0, 0, 0, 1'b0, 4'b0110));
    sample_q.push_back(make_sample(0, 0, 0, 1'b0, 4'b0011));
    sample_q.push_back(make_sample(255, 255, 255, 1'b0, 4'b1111));
    sample_q.push_back(make_sample(255, 255, 255, 1'b1, 4'b1111));
    sample_q.push_back(make_sample(85, 170, 1, 1'b0, 4'b0000));
    sample_q.push_back(make_sample(170, 85, 254, 1'b0, 4'b0000));

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      case (p)
        0: apply_setting(30, 1, 1, 0, 0);
        1: apply_setting(90, 4, 8, 20, 1);
        2: apply_setting(0, 0, 1, -20, 0);
        3: apply_setting(127, 7, 15, 31, 1);
        4: apply_setting(1, 2, 0, -32, 0);
        5: apply_setting(2, 3, 2, -1, 1);
        default: apply_setting($urandom_range(127), $urandom_range(7), $urandom_range(15),
                               int'($urandom_range(63)) - 32, $urandom_range(1));
      endcase
      set_pacing(p);
      queue_runs(173);
    end

    while (sample_q.size() != 0 || in_valid || wheel_expect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && wheel_expect_q.size() == 0) begin
      $display("** omni_drive_motor_mixer: PASSED **");
    end else begin
      $display("** omni_drive_motor_mixer: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t timeout", $time);
    $display("** omni_drive_motor_mixer: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
sv/odmm_pkg.sv
sv/omni_drive_motor_mixer.sv
test/omni_drive_motor_mixer_test.sv
